FILE: sv/bmhpq_pkg.sv
// Shared types and constants for the binary min-heap priority queue.
// No dependencies; the sequencer and the top import this package.
package bmhpq_pkg;

    localparam int WEIGHT_W  = 32;
    localparam int OUT_TAG_W = 16;
    localparam int OUT_CNT_W = 9;

    typedef enum logic [1:0] {
        REQ_ENQ  = 2'd0,
        REQ_DEQ  = 2'd1,
        REQ_PEEK = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_TOP,
        S_DOWN,
        S_FIN
    } t_state;

    typedef struct packed {
        t_status                       status;
        logic signed [WEIGHT_W-1:0]    weight;
        logic [OUT_TAG_W-1:0]          tag;
        logic [OUT_CNT_W-1:0]          count;
    } t_result;

endpackage

FILE: sv/bmhpq_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
// No dependencies; read during write at the same address returns old data.
module bmhpq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: sv/bmhpq_seq.sv
// Heap sequencer: request decode, sift-up and sift-down walks over the heap RAM.
// Depends on bmhpq_pkg and bmhpq_ram; hands finished results out as a t_result.
module bmhpq_seq
    import bmhpq_pkg::*;
#(
    parameter int HEAP_DEPTH = 256,
    parameter int TAG_BITS   = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_req_type,
    input  logic signed [WEIGHT_W-1:0] i_in_weight,
    input  logic [OUT_TAG_W-1:0]       i_in_tag,
    output logic                       o_res_valid,
    output t_result                    o_res,
    input  logic                       i_res_take
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int PW = CW + 1;
    localparam int EW = WEIGHT_W + TAG_BITS;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_pos, n_pos;
    logic [EW-1:0]         r_hold, n_hold;
    t_req                  r_req, n_req;
    t_status               r_status, n_status;
    logic [WEIGHT_W-1:0]   r_out_w, n_out_w;
    logic [OUT_TAG_W-1:0]  r_out_t, n_out_t;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [EW-1:0]         wdata;
    logic [AW-1:0]         raddr_a;
    logic [AW-1:0]         raddr_b;
    logic [EW-1:0]         rdata_a;
    logic [EW-1:0]         rdata_b;

    logic                  accept;
    logic [CW-1:0]         cnt_inc;
    logic [CW-1:0]         par;
    logic [PW-1:0]         left_pos;
    logic [PW-1:0]         right_pos;
    logic [PW-1:0]         cnt_ext;
    logic signed [WEIGHT_W-1:0] hold_w;
    logic signed [WEIGHT_W-1:0] a_w;
    logic signed [WEIGHT_W-1:0] b_w;
    logic                  lt_left;
    logic signed [WEIGHT_W-1:0] cur_w;
    logic                  take_right;
    logic [CW-1:0]         pick;
    logic [PW-1:0]         pick_dbl;

    bmhpq_ram #(
        .WIDTH (EW),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .o_rdata_a (rdata_a),
        .i_raddr_b (raddr_b),
        .o_rdata_b (rdata_b)
    );

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    // Walk helpers: parent for sift-up, children and winner for sift-down.
    assign cnt_inc    = r_count + CW'(1);
    assign par        = r_pos >> 1;
    assign left_pos   = {r_pos, 1'b0};
    assign right_pos  = left_pos | PW'(1);
    assign cnt_ext    = PW'(r_count);
    assign hold_w     = $signed(r_hold[EW-1 -: WEIGHT_W]);
    assign a_w        = $signed(rdata_a[EW-1 -: WEIGHT_W]);
    assign b_w        = $signed(rdata_b[EW-1 -: WEIGHT_W]);
    assign lt_left    = a_w < hold_w;
    assign cur_w      = lt_left ? a_w : hold_w;
    assign take_right = (right_pos <= cnt_ext) && (b_w < cur_w);
    assign pick       = take_right ? CW'(right_pos) : CW'(left_pos);
    assign pick_dbl   = {pick, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos    <= n_pos;
        r_hold   <= n_hold;
        r_req    <= n_req;
        r_status <= n_status;
        r_out_w  <= n_out_w;
        r_out_t  <= n_out_t;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_hold   = r_hold;
        n_req    = r_req;
        n_status = r_status;
        n_out_w  = r_out_w;
        n_out_t  = r_out_t;
        we       = 1'b0;
        waddr    = AW'(r_pos - CW'(1));
        wdata    = r_hold;
        raddr_a  = '0;
        raddr_b  = AW'(r_count - CW'(1));

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_out_w  = '0;
                    n_out_t  = '0;
                    n_req    = t_req'(i_req_type);
                    unique case (t_req'(i_req_type))
                        REQ_ENQ: begin
                            if (r_count == CW'(HEAP_DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_FIN;
                            end else begin
                                n_count = cnt_inc;
                                n_hold  = {i_in_weight, TAG_BITS'(i_in_tag)};
                                n_pos   = cnt_inc;
                                raddr_a = AW'((cnt_inc >> 1) - CW'(1));
                                n_state = S_UP;
                            end
                        end
                        REQ_DEQ, REQ_PEEK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_FIN;
                            end else begin
                                raddr_a = '0;
                                n_state = S_TOP;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_UP: begin
                if (r_pos == CW'(1)) begin
                    we      = 1'b1;
                    n_state = S_FIN;
                end else if (hold_w < a_w) begin
                    // Move the parent down into the hole, climb one level.
                    we      = 1'b1;
                    wdata   = rdata_a;
                    n_pos   = par;
                    raddr_a = AW'((par >> 1) - CW'(1));
                end else begin
                    we      = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_TOP: begin
                n_out_w = rdata_a[EW-1 -: WEIGHT_W];
                n_out_t = OUT_TAG_W'(rdata_a[TAG_BITS-1:0]);
                if (r_req == REQ_DEQ) begin
                    n_count = r_count - CW'(1);
                    n_hold  = rdata_b;
                    n_pos   = CW'(1);
                    raddr_a = AW'(1);
                    raddr_b = AW'(2);
                    n_state = (r_count == CW'(1)) ? S_FIN : S_DOWN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DOWN: begin
                if (left_pos > cnt_ext || (!lt_left && !take_right)) begin
                    we      = 1'b1;
                    n_state = S_FIN;
                end else begin
                    // Pull the lighter child up into the hole, descend.
                    we      = 1'b1;
                    wdata   = take_right ? rdata_b : rdata_a;
                    n_pos   = pick;
                    raddr_a = AW'(pick_dbl - PW'(1));
                    raddr_b = AW'(pick_dbl);
                end
            end
            S_FIN: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res_valid  = (r_state == S_FIN);
    assign o_res.status = r_status;
    assign o_res.weight = $signed(r_out_w);
    assign o_res.tag    = r_out_t;
    assign o_res.count  = OUT_CNT_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(HEAP_DEPTH))
        else $error("heap count above depth");

    a_walk_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP || r_state == S_DOWN) |-> (r_pos != '0 && r_pos <= r_count))
        else $error("walk position outside the filled heap");

    a_fin_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN || r_state == S_TOP) |-> !we)
        else $error("heap write outside a walk step");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_status == ST_FULL) |-> r_count == CW'(HEAP_DEPTH))
        else $error("full status with room left");

endmodule

FILE: sv/binary_min_heap_priority_queue_top.sv
// Binary min-heap priority queue, one request item in, one result item out.
// Enqueue sifts up and dequeue sifts down through the heap RAM, one tree level a
// cycle; peek only reads the root. A new request is taken only in the idle state,
// after the previous result has moved on to the output register, so output stalls
// hold off requests as well.
// Reset: synchronous, clears count and control; the heap RAM is not cleared and
// the queue takes items in the first cycle after reset.
module binary_min_heap_priority_queue_top
    import bmhpq_pkg::*;
#(
    parameter int HEAP_DEPTH = 256,
    parameter int TAG_BITS   = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_req_type,
    input  logic signed [WEIGHT_W-1:0] i_in_weight,
    input  logic [OUT_TAG_W-1:0]       i_in_tag,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_status,
    output logic signed [WEIGHT_W-1:0] o_out_weight,
    output logic [OUT_TAG_W-1:0]       o_out_tag,
    output logic [OUT_CNT_W-1:0]       o_entry_count
);

    logic    seq_valid;
    t_result seq_res;
    logic    res_take;

    logic    r_out_valid;
    t_result r_out;

    // The sequencer owns the heap RAM and the count; it parks each result
    // in its finish state until the output register can take it.
    bmhpq_seq #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .TAG_BITS   (TAG_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_req_type  (i_req_type),
        .i_in_weight (i_in_weight),
        .i_in_tag    (i_in_tag),
        .o_res_valid (seq_valid),
        .o_res       (seq_res),
        .i_res_take  (res_take)
    );

    // Output register: load when empty or being drained, hold while stalled.
    assign res_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= seq_valid;
        end
        if (res_take && seq_valid) begin
            r_out <= seq_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_out_weight  = r_out.weight;
    assign o_out_tag     = r_out.tag;
    assign o_entry_count = r_out.count;

    // Error results carry no entry.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> (r_out.weight == '0 && r_out.tag == '0))
        else $error("error result carries an entry");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_EMPTY) |-> r_out.count == '0)
        else $error("empty status with entries held");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_FULL) |-> r_out.count == OUT_CNT_W'(HEAP_DEPTH))
        else $error("full status below depth");

endmodule
